// ----- hw/rtl/ote_pkg.sv -----
`default_nettype none
package ote_pkg;

	// Function codes of an input item.
	localparam logic [1:0] FN_TICK   = 2'd0;
	localparam logic [1:0] FN_MARKET = 2'd1;
	localparam logic [1:0] FN_PEND   = 2'd2;
	localparam logic [1:0] FN_CANCEL = 2'd3;

	// Result kinds.
	localparam logic [2:0] K_DONE     = 3'd0;
	localparam logic [2:0] K_ACTIVATE = 3'd1;
	localparam logic [2:0] K_DROP     = 3'd2;
	localparam logic [2:0] K_CLOSE    = 3'd3;
	localparam logic [2:0] K_REJECT   = 3'd4;

	// Close reasons.
	localparam logic [1:0] R_STOP   = 2'd0;
	localparam logic [1:0] R_PROFIT = 2'd1;
	localparam logic [1:0] R_CANCEL = 2'd2;

	// Slot states.
	localparam logic [1:0] SL_FREE = 2'd0;
	localparam logic [1:0] SL_PEND = 2'd1;
	localparam logic [1:0] SL_ACT  = 2'd2;

	// List selectors.
	localparam logic LST_PEND = 1'b0;
	localparam logic LST_ACT  = 1'b1;

	localparam int ID_BITS   = 32;
	localparam int COMM_BITS = 24;
	localparam int EXP_BITS  = 32;

endpackage
`default_nettype wire

// ----- hw/rtl/order_trigger_engine_unit.sv -----
// Order trigger engine. Keeps up to ORDER_SLOTS orders in two linked lists, pending in
// placement order and active in activation order, and walks them with one slot
// evaluation unit that handles one slot per cycle while the output is not stalled. A
// market or pending order takes the lowest free slot, or is rejected when none is free.
// A cancel walks the pending list and then the active list until the order is found,
// and reports the target id when no order matches. A price tick walks the pending
// list, then the active list, and ends with a done result. Every result goes through
// one output register, so a stalled output holds the walk until the result is taken.
// The input is stalled while an item is in work. The commission register may be
// written at any time and is captured per order when the order is placed.
`default_nettype none
module order_trigger_engine_unit #(
	parameter int ORDER_SLOTS = 16,
	parameter int PRICE_BITS  = 32,
	parameter int TIME_BITS   = 48
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [ote_pkg::COMM_BITS-1:0] cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [1:0]                    func,
	input  wire logic [TIME_BITS-1:0]          tick_time,
	input  wire logic [PRICE_BITS-1:0]         tick_price,
	input  wire logic                          direction,
	input  wire logic [PRICE_BITS-1:0]         stop_loss,
	input  wire logic [PRICE_BITS-1:0]         take_profit,
	input  wire logic [ote_pkg::EXP_BITS-1:0]  expire_after,
	input  wire logic [PRICE_BITS-1:0]         drop_below,
	input  wire logic [PRICE_BITS-1:0]         drop_above,
	input  wire logic [PRICE_BITS-1:0]         enter_below,
	input  wire logic [PRICE_BITS-1:0]         enter_above,
	input  wire logic [ote_pkg::ID_BITS-1:0]   target_id,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               last,
	output logic [2:0]                         kind,
	output logic [ote_pkg::ID_BITS-1:0]        order_ref,
	output logic                               side,
	output logic [1:0]                         close_reason,
	output logic [TIME_BITS-1:0]               entry_time,
	output logic [TIME_BITS-1:0]               exit_time,
	output logic [PRICE_BITS-1:0]              open_price,
	output logic [PRICE_BITS-1:0]              close_price,
	output logic [TIME_BITS-1:0]               held_time,
	output logic signed [PRICE_BITS:0]         gross_profit,
	output logic signed [PRICE_BITS+1:0]       net_gain
);

	localparam int SW = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
	localparam int LW = $clog2(ORDER_SLOTS + 1);
	localparam int PW = PRICE_BITS;
	localparam int TW = TIME_BITS;
	localparam int GW = PRICE_BITS + 1;
	localparam int NW = PRICE_BITS + 2;
	localparam int CW = (TIME_BITS > ote_pkg::EXP_BITS) ? TIME_BITS : ote_pkg::EXP_BITS;
	localparam int IW = ote_pkg::ID_BITS;

	typedef enum logic [2:0] {
		S_IDLE, S_PLACE, S_PEND, S_ACT, S_DONE, S_CANC
	} state_t;

	state_t state_q;

	// Control state.
	logic [1:0]    slot_list_q [ORDER_SLOTS];
	logic [SW-1:0] head_q [2];
	logic [SW-1:0] tail_q [2];
	logic [LW-1:0] len_q [2];
	logic [SW-1:0] cur_q, prev_q;
	logic          has_prev_q;
	logic [LW-1:0] left_q;
	logic          lst_q;
	logic [ote_pkg::COMM_BITS-1:0] comm_q;
	logic [TW-1:0] now_time_q;
	logic [PW-1:0] now_price_q;
	logic [IW-1:0] id_q;

	// Latched item.
	logic [1:0]    func_q;
	logic          dir_q;
	logic [PW-1:0] sl_in_q, tp_in_q, db_in_q, da_in_q, eb_in_q, ea_in_q;
	logic [ote_pkg::EXP_BITS-1:0] exp_in_q;
	logic [IW-1:0] target_q;

	// Slot stores.
	logic [SW-1:0] slot_next_q [ORDER_SLOTS];
	logic          slot_side_q [ORDER_SLOTS];
	logic [IW-1:0] slot_id_q [ORDER_SLOTS];
	logic [TW-1:0] slot_req_q [ORDER_SLOTS];
	logic [TW-1:0] slot_et_q [ORDER_SLOTS];
	logic [PW-1:0] slot_ep_q [ORDER_SLOTS];
	logic [PW-1:0] slot_sl_q [ORDER_SLOTS];
	logic [PW-1:0] slot_tp_q [ORDER_SLOTS];
	logic [ote_pkg::EXP_BITS-1:0] slot_exp_q [ORDER_SLOTS];
	logic [PW-1:0] slot_db_q [ORDER_SLOTS];
	logic [PW-1:0] slot_da_q [ORDER_SLOTS];
	logic [PW-1:0] slot_eb_q [ORDER_SLOTS];
	logic [PW-1:0] slot_ea_q [ORDER_SLOTS];
	logic [ote_pkg::COMM_BITS-1:0] slot_comm_q [ORDER_SLOTS];

	// Output register.
	logic          out_valid_q, last_q, side_q;
	logic [2:0]    kind_q;
	logic [1:0]    reason_q;
	logic [IW-1:0] ref_q;
	logic [TW-1:0] et_q, xt_q, ht_q;
	logic [PW-1:0] ep_q, xp_q;
	logic [GW-1:0] gp_q;
	logic [NW-1:0] np_q;

	logic in_acc, go;
	assign in_acc = in_valid && !in_stall;
	assign go = !out_valid_q || !out_stall;

	// Lowest free slot.
	logic          free_found;
	logic [SW-1:0] free_idx;
	always_comb begin
		free_found = 1'b0;
		free_idx = '0;
		for (int i = ORDER_SLOTS - 1; i >= 0; i--) begin
			if (slot_list_q[i] == ote_pkg::SL_FREE) begin
				free_found = 1'b1;
				free_idx = SW'(i);
			end
		end
	end

	// Slot evaluation unit, working on the slot at cur_q.
	logic [SW-1:0] nxt_cur;
	logic [TW-1:0] age;
	logic          drop_hit, enter_hit, sl_hit, tp_hit, id_hit;
	logic [GW-1:0] diff, gross;
	logic [NW-1:0] net;
	always_comb begin
		nxt_cur = slot_next_q[cur_q];
		age = now_time_q - slot_req_q[cur_q];
		drop_hit = (slot_exp_q[cur_q] != '0
				&& CW'(age) >= CW'(slot_exp_q[cur_q]))
			|| (slot_db_q[cur_q] != '0 && now_price_q <= slot_db_q[cur_q])
			|| (slot_da_q[cur_q] != '0 && now_price_q >= slot_da_q[cur_q]);
		enter_hit = (slot_eb_q[cur_q] != '0 && now_price_q <= slot_eb_q[cur_q])
			|| (slot_ea_q[cur_q] != '0 && now_price_q >= slot_ea_q[cur_q]);
		sl_hit = slot_sl_q[cur_q] != '0 && (slot_side_q[cur_q]
			? now_price_q >= slot_sl_q[cur_q] : now_price_q <= slot_sl_q[cur_q]);
		tp_hit = slot_tp_q[cur_q] != '0 && (slot_side_q[cur_q]
			? now_price_q <= slot_tp_q[cur_q] : now_price_q >= slot_tp_q[cur_q]);
		id_hit = slot_id_q[cur_q] == target_q;
		diff = {1'b0, now_price_q} - {1'b0, slot_ep_q[cur_q]};
		gross = slot_side_q[cur_q] ? -diff : diff;
		net = {gross[GW-1], gross} - NW'(slot_comm_q[cur_q]);
	end

	// Step decisions and the result to emit.
	logic          emit, e_last, e_side;
	logic [2:0]    e_kind;
	logic [1:0]    e_reason;
	logic [IW-1:0] e_ref;
	logic [TW-1:0] e_et, e_xt, e_ht;
	logic [PW-1:0] e_ep, e_xp;
	logic [GW-1:0] e_gp;
	logic [NW-1:0] e_np;
	logic          rm_en, app_en, app_lst;
	logic [SW-1:0] app_slot;

	always_comb begin
		emit = 1'b0;
		e_last = 1'b0;
		e_kind = ote_pkg::K_DONE;
		e_reason = ote_pkg::R_STOP;
		e_ref = '0;
		e_side = 1'b0;
		e_et = '0;
		e_xt = '0;
		e_ht = '0;
		e_ep = '0;
		e_xp = '0;
		e_gp = '0;
		e_np = '0;
		rm_en = 1'b0;
		app_en = 1'b0;
		app_lst = ote_pkg::LST_PEND;
		app_slot = cur_q;
		if (go) begin
			unique case (state_q)
				S_PLACE: begin
					emit = 1'b1;
					e_last = 1'b1;
					e_side = dir_q;
					if (!free_found) begin
						e_kind = ote_pkg::K_REJECT;
					end else begin
						app_en = 1'b1;
						app_slot = free_idx;
						e_ref = id_q + 1'b1;
						if (func_q == ote_pkg::FN_MARKET) begin
							app_lst = ote_pkg::LST_ACT;
							e_et = now_time_q;
							e_ep = now_price_q;
						end
					end
				end
				S_PEND: begin
					if (left_q != '0 && (drop_hit || enter_hit)) begin
						emit = 1'b1;
						rm_en = 1'b1;
						e_ref = slot_id_q[cur_q];
						e_side = slot_side_q[cur_q];
						if (drop_hit) begin
							e_kind = ote_pkg::K_DROP;
						end else begin
							e_kind = ote_pkg::K_ACTIVATE;
							app_en = 1'b1;
							app_lst = ote_pkg::LST_ACT;
							e_et = now_time_q;
							e_ep = now_price_q;
						end
					end
				end
				S_ACT, S_CANC: begin
					if (left_q != '0 && ((state_q == S_ACT && (sl_hit || tp_hit))
							|| (state_q == S_CANC && id_hit))) begin
						emit = 1'b1;
						rm_en = 1'b1;
						e_ref = slot_id_q[cur_q];
						e_side = slot_side_q[cur_q];
						e_last = state_q == S_CANC;
						if (state_q == S_CANC && lst_q == ote_pkg::LST_PEND) begin
							e_kind = ote_pkg::K_DROP;
						end else begin
							e_kind = ote_pkg::K_CLOSE;
							if (state_q == S_CANC) e_reason = ote_pkg::R_CANCEL;
							else if (sl_hit) e_reason = ote_pkg::R_STOP;
							else e_reason = ote_pkg::R_PROFIT;
							e_et = slot_et_q[cur_q];
							e_xt = now_time_q;
							e_ep = slot_ep_q[cur_q];
							e_xp = now_price_q;
							e_ht = now_time_q - slot_et_q[cur_q];
							e_gp = gross;
							e_np = net;
						end
					end else if (state_q == S_CANC && left_q == '0
							&& lst_q == ote_pkg::LST_ACT) begin
						// Not found in either list.
						emit = 1'b1;
						e_last = 1'b1;
						e_ref = target_q;
					end
				end
				S_DONE: begin
					emit = 1'b1;
					e_last = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	logic rm_lst;
	assign rm_lst = (state_q == S_CANC) ? lst_q
		: ((state_q == S_ACT) ? ote_pkg::LST_ACT : ote_pkg::LST_PEND);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int i = 0; i < ORDER_SLOTS; i++) slot_list_q[i] <= ote_pkg::SL_FREE;
			for (int l = 0; l < 2; l++) begin
				head_q[l] <= '0;
				tail_q[l] <= '0;
				len_q[l] <= '0;
			end
			cur_q <= '0;
			prev_q <= '0;
			has_prev_q <= 1'b0;
			left_q <= '0;
			lst_q <= ote_pkg::LST_PEND;
			comm_q <= '0;
			now_time_q <= '0;
			now_price_q <= '0;
			id_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) comm_q <= cfg_data;
			if (emit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;

			if (rm_en) begin
				if (!has_prev_q) head_q[rm_lst] <= nxt_cur;
				if (tail_q[rm_lst] == cur_q) tail_q[rm_lst] <= prev_q;
				len_q[rm_lst] <= len_q[rm_lst] - 1'b1;
				// An activated slot moves straight to the active state below.
				if (!app_en) slot_list_q[cur_q] <= ote_pkg::SL_FREE;
			end
			if (app_en) begin
				slot_list_q[app_slot] <= (app_lst == ote_pkg::LST_ACT)
					? ote_pkg::SL_ACT : ote_pkg::SL_PEND;
				if (len_q[app_lst] == '0) head_q[app_lst] <= app_slot;
				tail_q[app_lst] <= app_slot;
				len_q[app_lst] <= len_q[app_lst] + 1'b1;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						has_prev_q <= 1'b0;
						lst_q <= ote_pkg::LST_PEND;
						cur_q <= head_q[ote_pkg::LST_PEND];
						left_q <= len_q[ote_pkg::LST_PEND];
						unique case (func)
							ote_pkg::FN_TICK: begin
								now_time_q <= tick_time;
								now_price_q <= tick_price;
								state_q <= S_PEND;
							end
							ote_pkg::FN_CANCEL: state_q <= S_CANC;
							default: state_q <= S_PLACE;
						endcase
					end
				end
				S_PLACE: begin
					if (go) begin
						if (free_found) id_q <= id_q + 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_PEND, S_ACT, S_CANC: begin
					if (go) begin
						if (left_q == '0) begin
							has_prev_q <= 1'b0;
							cur_q <= head_q[ote_pkg::LST_ACT];
							left_q <= len_q[ote_pkg::LST_ACT];
							lst_q <= ote_pkg::LST_ACT;
							if (state_q == S_PEND) state_q <= S_ACT;
							else if (state_q == S_ACT) state_q <= S_DONE;
							else if (lst_q == ote_pkg::LST_ACT) state_q <= S_IDLE;
						end else if (state_q == S_CANC && rm_en) begin
							state_q <= S_IDLE;
						end else begin
							if (!rm_en) begin
								prev_q <= cur_q;
								has_prev_q <= 1'b1;
							end
							cur_q <= nxt_cur;
							left_q <= left_q - 1'b1;
						end
					end
				end
				S_DONE: begin
					if (go) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Slot stores and the output payload.
	always_ff @(posedge clk) begin
		if (rm_en && has_prev_q) slot_next_q[prev_q] <= nxt_cur;
		if (app_en && len_q[app_lst] != '0) slot_next_q[tail_q[app_lst]] <= app_slot;
		if (app_en && state_q == S_PEND) begin
			slot_et_q[cur_q] <= now_time_q;
			slot_ep_q[cur_q] <= now_price_q;
		end
		if (app_en && state_q == S_PLACE) begin
			slot_id_q[app_slot] <= id_q + 1'b1;
			slot_side_q[app_slot] <= dir_q;
			slot_req_q[app_slot] <= now_time_q;
			slot_comm_q[app_slot] <= comm_q;
			slot_sl_q[app_slot] <= sl_in_q;
			slot_tp_q[app_slot] <= tp_in_q;
			slot_exp_q[app_slot] <= exp_in_q;
			slot_db_q[app_slot] <= db_in_q;
			slot_da_q[app_slot] <= da_in_q;
			slot_eb_q[app_slot] <= eb_in_q;
			slot_ea_q[app_slot] <= ea_in_q;
			slot_et_q[app_slot] <= e_et;
			slot_ep_q[app_slot] <= e_ep;
		end
		if (in_acc) begin
			func_q <= func;
			dir_q <= direction;
			sl_in_q <= stop_loss;
			tp_in_q <= take_profit;
			exp_in_q <= expire_after;
			db_in_q <= drop_below;
			da_in_q <= drop_above;
			eb_in_q <= enter_below;
			ea_in_q <= enter_above;
			target_q <= target_id;
		end
		if (emit) begin
			last_q <= e_last;
			kind_q <= e_kind;
			ref_q <= e_ref;
			side_q <= e_side;
			reason_q <= e_reason;
			et_q <= e_et;
			xt_q <= e_xt;
			ep_q <= e_ep;
			xp_q <= e_xp;
			ht_q <= e_ht;
			gp_q <= e_gp;
			np_q <= e_np;
		end
	end

	assign cfg_ready = 1'b1;
	assign in_stall = state_q != S_IDLE;
	assign out_valid = out_valid_q;
	assign last = last_q;
	assign kind = kind_q;
	assign order_ref = ref_q;
	assign side = side_q;
	assign close_reason = reason_q;
	assign entry_time = et_q;
	assign exit_time = xt_q;
	assign open_price = ep_q;
	assign close_price = xp_q;
	assign held_time = ht_q;
	assign gross_profit = gp_q;
	assign net_gain = np_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		((LW+1)'(len_q[0]) + (LW+1)'(len_q[1])) <= (LW+1)'(ORDER_SLOTS))
		else $error("list lengths exceed slot count");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!out_valid_q || !out_stall))
		else $error("result overwrites a waiting item");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q != S_IDLE)
		else $error("accepted item not taken into work");
	a_rm_used: assert property (@(posedge clk) disable iff (!arst_n)
		rm_en |-> slot_list_q[cur_q] != ote_pkg::SL_FREE)
		else $error("removing a free slot");

endmodule
`default_nettype wire
